>>> src/csdr_pkg.sv
// Package for the constant signed-digit recoder: widths, digit codes,
// controller/datapath command and status structs, and the digit weight function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csdr_pkg;

  localparam int CSDR_DIGITS     = 32;
  localparam int CSDR_INT_DIGITS = 16;

  localparam int VAL_W     = 32;  // constant and tolerance, unsigned 16.16
  localparam int CFG_W     = 6;   // input_width register
  localparam int POS_W     = 5;   // digit_position
  localparam int DIG_W     = 2;   // signed digit
  localparam int CNT_W     = 6;   // term_count
  localparam int RES_OUT_W = 34;  // residual on the output
  localparam int RES_W     = 35;  // residual held internally, one guard bit

  localparam logic [CFG_W-1:0] INPUT_WIDTH_RST = 6'd8;

  typedef logic signed [DIG_W-1:0] digit_t;

  localparam digit_t DIG_ZERO = 2'sb00;
  localparam digit_t DIG_POS  = 2'sb01;
  localparam digit_t DIG_NEG  = 2'sb11;

  typedef struct packed {
    logic load;
    logic recode;
    logic walk_init;
    logic walk;
    logic emit_init;
    logic emit;
  } csdr_cmd_t;

  typedef struct packed {
    logic recode_end;
    logic walk_end;
    logic out_free;
    logic emit_end;
  } csdr_sts_t;

  // Weight of digit j in units of 2^-16. Only weights that a nonzero digit can
  // carry are representable; everything else reads as zero.
  function automatic logic [RES_W-1:0] weight_of(input int int_digits, input int j);
    int e;
    e = int_digits + 15 - j;
    if (e < 0 || e > RES_W - 2) begin
      return '0;
    end
    return RES_W'(1) << e;
  endfunction

endpackage

`default_nettype wire

>>> src/csdr_in_if.sv
// Input channel of the recoder: valid/ready handshake with the constant and
// its tolerance. Depends on csdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface csdr_in_if import csdr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] constant_value;
  logic [VAL_W-1:0] tolerance;

  modport source (output valid, output constant_value, output tolerance, input ready);
  modport sink   (input valid, input constant_value, input tolerance, output ready);
endinterface

`default_nettype wire

>>> src/csdr_out_if.sv
// Result channel of the recoder: one word per signed digit, with the summary
// fields on the last one. Depends on csdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface csdr_out_if import csdr_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [POS_W-1:0]            digit_position;
  digit_t                      digit_value;
  logic                        last_digit;
  logic [CNT_W-1:0]            term_count;
  logic                        precision_warning;
  logic signed [RES_OUT_W-1:0] residual;

  modport source (output valid, output digit_position, output digit_value,
                  output last_digit, output term_count, output precision_warning,
                  output residual, input ready);
  modport sink   (input valid, input digit_position, input digit_value,
                  input last_digit, input term_count, input precision_warning,
                  input residual, output ready);
endinterface

`default_nettype wire

>>> src/constant_signed_digit_recoder.sv
// Constant signed-digit recoder, top level. Depends on csdr_pkg, the channel
// interfaces, csdr_ctrl and csdr_dpath.
// One item occupies the block from acceptance until the next can be taken: DIGITS
// recode steps, W walk steps up to the stop, and L emitted words at one per cycle
// while out ready is high.
// Reset is synchronous and active low; it sets input_width to 8 and clears control.
`timescale 1ns / 1ps
`default_nettype none

module constant_signed_digit_recoder import csdr_pkg::*; #(
  parameter int DIGITS     = CSDR_DIGITS,
  parameter int INT_DIGITS = CSDR_INT_DIGITS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  csdr_in_if.sink               in_chan,
  csdr_out_if.source            out_chan,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data
);

  csdr_cmd_t cmd;
  csdr_sts_t sts;

  csdr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  csdr_dpath #(
    .DIGITS     (DIGITS),
    .INT_DIGITS (INT_DIGITS)
  ) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_constant_value     (in_chan.constant_value),
    .in_tolerance          (in_chan.tolerance),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .out_valid             (out_chan.valid),
    .out_ready             (out_chan.ready),
    .out_digit_position    (out_chan.digit_position),
    .out_digit_value       (out_chan.digit_value),
    .out_last_digit        (out_chan.last_digit),
    .out_term_count        (out_chan.term_count),
    .out_precision_warning (out_chan.precision_warning),
    .out_residual          (out_chan.residual)
  );

endmodule

`default_nettype wire

>>> src/csdr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module csdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/csdr_ctrl.sv
// Controller of the recoder: sequences load, recode, walk and emit phases.
// Depends on csdr_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module csdr_ctrl import csdr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  csdr_sts_t      sts,
  output csdr_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_RECODE    = 3'd1;
  localparam logic [2:0] S_WALK_PREP = 3'd2;
  localparam logic [2:0] S_WALK      = 3'd3;
  localparam logic [2:0] S_EMIT_PREP = 3'd4;
  localparam logic [2:0] S_EMIT      = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RECODE;
        end
      end
      S_RECODE: begin
        cmd.recode = 1'b1;
        if (sts.recode_end) begin
          state_nxt = S_WALK_PREP;
        end
      end
      S_WALK_PREP: begin
        cmd.walk_init = 1'b1;
        state_nxt     = S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_end) begin
          state_nxt = S_EMIT_PREP;
        end
      end
      S_EMIT_PREP: begin
        cmd.emit_init = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_end) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/csdr_dpath.sv
// Datapath of the recoder: binary expansion, run-of-ones recoding into the
// digit store, residual walk and the output word register.
// Depends on csdr_pkg and csdr_ram.
`timescale 1ns / 1ps
`default_nettype none

module csdr_dpath import csdr_pkg::*; #(
  parameter int DIGITS     = CSDR_DIGITS,
  parameter int INT_DIGITS = CSDR_INT_DIGITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  csdr_cmd_t                     cmd,
  output csdr_sts_t                     sts,
  input  wire logic [VAL_W-1:0]         in_constant_value,
  input  wire logic [VAL_W-1:0]         in_tolerance,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_W-1:0]         cfg_wr_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [POS_W-1:0]              out_digit_position,
  output digit_t                        out_digit_value,
  output logic                          out_last_digit,
  output logic [CNT_W-1:0]              out_term_count,
  output logic                          out_precision_warning,
  output logic signed [RES_OUT_W-1:0]   out_residual
);

  localparam int IW      = $clog2(DIGITS);
  localparam int TW      = $clog2(DIGITS + 1);
  localparam int CMP_W   = 8;
  localparam int TOP_EXP = INT_DIGITS + 15;
  localparam logic [CMP_W-1:0] BASE_MIN = CMP_W'(INT_DIGITS - 1);
  localparam logic [IW-1:0]    IDX_LAST = IW'(DIGITS - 1);

  // Configuration and per-item registers.
  logic [CFG_W-1:0]        iw_r;
  logic [VAL_W-1:0]        c_r, c_nxt;
  logic [VAL_W-1:0]        tol_r, tol_nxt;
  logic [DIGITS-1:0]       sh_r, sh_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic                    run_r, run_nxt;
  logic signed [RES_W-1:0] res_r, res_nxt;
  logic [TW-1:0]           terms_r, terms_nxt;
  logic [IW-1:0]           last_nz_r, last_nz_nxt;
  logic                    warn_r, warn_nxt;
  logic [IW-1:0]           lastidx_r, lastidx_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Output word payload.
  logic [POS_W-1:0]            pos_r;
  digit_t                      dig_r;
  logic                        last_r;
  logic [CNT_W-1:0]            tc_r;
  logic                        owarn_r;
  logic signed [RES_OUT_W-1:0] ores_r;

  logic [DIGITS-1:0] exp_vec;
  logic              sat;
  digit_t            q;
  digit_t            rc_dig;
  logic              rc_run;
  logic              rc_v;

  logic [CMP_W-1:0]        base8;
  logic                    width_stop;
  logic [RES_W-1:0]        wt;
  logic signed [RES_W-1:0] wk_res;
  logic [TW-1:0]           wk_terms;
  logic signed [RES_W-1:0] tol_s;
  logic                    tol_met;
  logic                    is_last;

  // Greedy expansion over descending powers of two is the binary pattern of
  // the constant, or all ones when the constant exceeds the top weight.
  // Bit i of the vector is digit DIGITS-1-i, so the recode pass shifts right.
  always_comb begin
    int e;
    sat     = (TOP_EXP < VAL_W - 1) && ((in_constant_value >> (TOP_EXP + 1)) != '0);
    exp_vec = '0;
    for (int i = 0; i < DIGITS; i++) begin
      e = INT_DIGITS + 16 - DIGITS + i;
      exp_vec[i] = (e >= 0) && (sat || ((e < VAL_W) && in_constant_value[e[4:0]]));
    end
  end

  // Recode one digit, least significant first. A run of three or more ones
  // becomes -1 at its bottom, zeros inside and +1 at the first zero above it;
  // that +1 is then checked again against the two digits above it.
  always_comb begin
    rc_v = run_r | sh_r[0];
    if (run_r && sh_r[0]) begin
      rc_dig = DIG_ZERO;
      rc_run = 1'b1;
    end else if ((idx_r > IW'(1)) && rc_v && sh_r[1] && sh_r[2]) begin
      rc_dig = DIG_NEG;
      rc_run = 1'b1;
    end else begin
      rc_dig = rc_v ? DIG_POS : DIG_ZERO;
      rc_run = 1'b0;
    end
  end

  // Residual walk, most significant digit first.
  always_comb begin
    base8      = (CMP_W'(last_nz_r) > BASE_MIN) ? CMP_W'(last_nz_r) : BASE_MIN;
    width_stop = CMP_W'(idx_r) >= (base8 + CMP_W'(iw_r));
    wt         = weight_of(INT_DIGITS, int'(idx_r));
    case (q)
      DIG_POS: wk_res = res_r - $signed(wt);
      DIG_NEG: wk_res = res_r + $signed(wt);
      default: wk_res = res_r;
    endcase
    wk_terms = (q != DIG_ZERO) ? terms_r + 1'b1 : terms_r;
    tol_s    = $signed({{(RES_W - VAL_W){1'b0}}, tol_r});
    tol_met  = (wk_res <= tol_s) && (wk_res >= -tol_s);
  end

  assign is_last = (idx_r == lastidx_r);

  assign sts.recode_end = (idx_r == '0);
  assign sts.walk_end   = width_stop || tol_met || (idx_r == IDX_LAST);
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.emit_end   = is_last;

  always_comb begin
    c_nxt       = c_r;
    tol_nxt     = tol_r;
    sh_nxt      = sh_r;
    idx_nxt     = idx_r;
    run_nxt     = run_r;
    res_nxt     = res_r;
    terms_nxt   = terms_r;
    last_nz_nxt = last_nz_r;
    warn_nxt    = warn_r;
    lastidx_nxt = lastidx_r;
    if (cmd.load) begin
      c_nxt   = in_constant_value;
      tol_nxt = in_tolerance;
      sh_nxt  = exp_vec;
      idx_nxt = IDX_LAST;
      run_nxt = 1'b0;
    end
    if (cmd.recode) begin
      run_nxt = rc_run;
      sh_nxt  = sh_r >> 1;
      if (idx_r != '0) begin
        idx_nxt = idx_r - 1'b1;
      end
    end
    if (cmd.walk_init) begin
      idx_nxt     = '0;
      res_nxt     = $signed({{(RES_W - VAL_W){1'b0}}, c_r});
      terms_nxt   = '0;
      last_nz_nxt = '0;
      warn_nxt    = 1'b0;
    end
    if (cmd.walk) begin
      if (width_stop) begin
        // Truncate at the last nonzero digit walked so far.
        warn_nxt    = 1'b1;
        lastidx_nxt = last_nz_r;
      end else begin
        res_nxt   = wk_res;
        terms_nxt = wk_terms;
        if (tol_met || (idx_r == IDX_LAST)) begin
          lastidx_nxt = idx_r;
        end else begin
          if (q != DIG_ZERO) begin
            last_nz_nxt = idx_r;
          end
          idx_nxt = idx_r + 1'b1;
        end
      end
    end
    if (cmd.emit_init) begin
      idx_nxt = '0;
    end
    if (cmd.emit) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r        <= INPUT_WIDTH_RST;
      idx_r       <= '0;
      run_r       <= 1'b0;
      res_r       <= '0;
      terms_r     <= '0;
      last_nz_r   <= '0;
      warn_r      <= 1'b0;
      lastidx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        iw_r <= cfg_wr_data;
      end
      idx_r       <= idx_nxt;
      run_r       <= run_nxt;
      res_r       <= res_nxt;
      terms_r     <= terms_nxt;
      last_nz_r   <= last_nz_nxt;
      warn_r      <= warn_nxt;
      lastidx_r   <= lastidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r   <= c_nxt;
    tol_r <= tol_nxt;
    sh_r  <= sh_nxt;
    if (cmd.emit) begin
      pos_r   <= POS_W'(idx_r);
      dig_r   <= q;
      last_r  <= is_last;
      tc_r    <= is_last ? CNT_W'(terms_r) : '0;
      owarn_r <= is_last && warn_r;
      ores_r  <= is_last ? res_r[RES_OUT_W-1:0] : '0;
    end
  end

  // The read address follows the next index, so the registered read data
  // always belongs to the current index.
  csdr_ram #(
    .WIDTH (DIG_W),
    .DEPTH (DIGITS)
  ) u_digit_store (
    .clk   (clk),
    .we    (cmd.recode),
    .waddr (idx_r),
    .wdata (rc_dig),
    .raddr (idx_nxt),
    .rdata (q)
  );

  assign out_valid             = out_valid_r;
  assign out_digit_position    = pos_r;
  assign out_digit_value       = dig_r;
  assign out_last_digit        = last_r;
  assign out_term_count        = tc_r;
  assign out_precision_warning = owarn_r;
  assign out_residual          = ores_r;

endmodule

`default_nettype wire

>>> src/csdr_checker.sv
// Port-level checks of the recoder, bound to the top level.
// Depends on csdr_pkg and constant_signed_digit_recoder.
`timescale 1ns / 1ps
`default_nettype none

module csdr_checker import csdr_pkg::*; (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [POS_W-1:0]            out_digit_position,
  input wire logic [DIG_W-1:0]            out_digit_value,
  input wire logic                        out_last_digit,
  input wire logic [CNT_W-1:0]            out_term_count,
  input wire logic                        out_precision_warning,
  input wire logic signed [RES_OUT_W-1:0] out_residual
);

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit_position) &&
      $stable(out_digit_value) && $stable(out_last_digit) && $stable(out_residual))
    else $error("stalled result word changed");

  // The block works on one constant at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again straight after an accepted word");

  // The summary fields are zero on every word but the last.
  a_summary_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_digit |-> (out_term_count == '0) &&
      !out_precision_warning && (out_residual == '0))
    else $error("summary field set on a word that is not the last");

  a_digit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_value == DIG_ZERO) || (out_digit_value == DIG_POS) ||
      (out_digit_value == DIG_NEG))
    else $error("digit value outside -1, 0, +1");

endmodule

bind constant_signed_digit_recoder csdr_checker u_csdr_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_chan.valid),
  .in_ready              (in_chan.ready),
  .out_valid             (out_chan.valid),
  .out_ready             (out_chan.ready),
  .out_digit_position    (out_chan.digit_position),
  .out_digit_value       (out_chan.digit_value),
  .out_last_digit        (out_chan.last_digit),
  .out_term_count        (out_chan.term_count),
  .out_precision_warning (out_chan.precision_warning),
  .out_residual          (out_chan.residual)
);

`default_nettype wire
